@@ hw/rtl/h2dva_pkg.sv @@
// ----------------------------------------------------------------------------
// h2dva_pkg
// Shared types and constants of the two-dimensional value histogram.
// ----------------------------------------------------------------------------
package h2dva_pkg;

  localparam int MAX_BINS_X = 64;
  localparam int MAX_BINS_Y = 64;
  localparam int CELLS      = MAX_BINS_X * MAX_BINS_Y;
  localparam int ADDR_W     = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int XI_W       = (MAX_BINS_X > 1) ? $clog2(MAX_BINS_X) : 1;
  localparam int YI_W       = (MAX_BINS_Y > 1) ? $clog2(MAX_BINS_Y) : 1;

  localparam int SUM_W   = 48;
  localparam int CNT_W   = 32;
  localparam int COORD_W = 32;
  localparam int BINS_W  = 7;
  localparam int HIT_W   = 6;
  localparam int RBIN_W  = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_ORIGIN = 3'd0,
    REG_Y_ORIGIN = 3'd1,
    REG_X_INV    = 3'd2,
    REG_Y_INV    = 3'd3,
    REG_X_BINS   = 3'd4,
    REG_Y_BINS   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic                      operation;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic signed [COORD_W-1:0] sample_value;
    logic signed [RBIN_W-1:0]  read_bin_x;
    logic signed [RBIN_W-1:0]  read_bin_y;
  } in_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] bin_sum;
    logic [CNT_W-1:0]        bin_count;
    logic [HIT_W-1:0]        hit_x_index;
    logic [HIT_W-1:0]        hit_y_index;
    logic [CNT_W-1:0]        total_entries;
  } out_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        cnt;
  } bin_word_t;

  function automatic logic [BINS_W-1:0] eff_bins(logic [BINS_W-1:0] r, int maxb);
    logic [BINS_W-1:0] v;
    if (r == '0) begin
      v = BINS_W'(1);
    end else if (32'(r) > 32'(maxb)) begin
      v = BINS_W'(maxb);
    end else begin
      v = r;
    end
    return v;
  endfunction

endpackage

@@ hw/rtl/histogram_2d_value_accumulate_core.sv @@
// ----------------------------------------------------------------------------
// histogram_2d_value_accumulate_core
// Two-dimensional binned accumulator: per-bin saturating value sum and hit
// count in one synchronous memory, plus a saturating total entry count.
// ----------------------------------------------------------------------------
// Each transaction runs to completion before the next input is taken: the
// accept cycle captures the input and subtracts the origin, then come the
// reciprocal multiply, clamp and address, memory read, and the read-modify-write
// into the bin memory, with the result loaded into the output register at its
// commit. A result still waiting in the output register holds the block in its
// last cycle until it is taken. After reset a clearing pass zeroes all 4096
// entries of the bin memory one entry per cycle, during which no input is
// taken; configuration writes are taken at all times. One result per input item.
// ----------------------------------------------------------------------------
module histogram_2d_value_accumulate_core
  import h2dva_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_MUL, S_IDX, S_MEM, S_RD
  } state_t;

  state_t state_r, state_nxt;

  logic [ADDR_W-1:0]        clr_cnt_r, clr_cnt_nxt;
  logic signed [COORD_W-1:0] x_origin_r, x_origin_nxt, y_origin_r, y_origin_nxt;
  logic [31:0]              x_inv_r, x_inv_nxt, y_inv_r, y_inv_nxt;
  logic [BINS_W-1:0]        x_bins_r, x_bins_nxt, y_bins_r, y_bins_nxt;
  logic [CNT_W-1:0]         total_r, total_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_r, out_nxt;

  logic                     op_r, op_nxt;
  logic [31:0]              dx_r, dx_nxt, dy_r, dy_nxt;
  logic [31:0]              qx_r, qx_nxt, qy_r, qy_nxt;
  logic signed [COORD_W-1:0] val_r, val_nxt;
  logic signed [RBIN_W-1:0] rbx_r, rbx_nxt, rby_r, rby_nxt;
  logic [XI_W-1:0]          hx_r, hx_nxt;
  logic [YI_W-1:0]          hy_r, hy_nxt;
  logic [ADDR_W-1:0]        addr_r, addr_nxt;
  logic                     rd_ok_r, rd_ok_nxt;

  bin_word_t                mem [CELLS];
  bin_word_t                rd_word_r;
  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_wa;
  bin_word_t                mem_wd;

  logic [BINS_W-1:0]        eff_x, eff_y;
  logic signed [COORD_W:0]  diff_x, diff_y;
  logic [63:0]              prod_x, prod_y;
  logic [XI_W-1:0]          cl_x;
  logic [YI_W-1:0]          cl_y;
  logic signed [SUM_W:0]    sum_ext;
  logic signed [SUM_W-1:0]  sum_sat;
  logic                     commit;

  assign eff_x = eff_bins(x_bins_r, MAX_BINS_X);
  assign eff_y = eff_bins(y_bins_r, MAX_BINS_Y);

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign diff_x = (COORD_W+1)'(in_data.x_coord) - (COORD_W+1)'(x_origin_r);
  assign diff_y = (COORD_W+1)'(in_data.y_coord) - (COORD_W+1)'(y_origin_r);
  assign prod_x = {32'd0, dx_r} * {32'd0, x_inv_r};
  assign prod_y = {32'd0, dy_r} * {32'd0, y_inv_r};

  assign cl_x = (qx_r >= 32'(eff_x)) ? XI_W'(eff_x - 1'b1) : XI_W'(qx_r);
  assign cl_y = (qy_r >= 32'(eff_y)) ? YI_W'(eff_y - 1'b1) : YI_W'(qy_r);

  assign sum_ext = (SUM_W+1)'(rd_word_r.sum) + (SUM_W+1)'(val_r);
  always_comb begin
    if (sum_ext > $signed((SUM_W+1)'({1'b0, {(SUM_W-1){1'b1}}}))) begin
      sum_sat = {1'b0, {(SUM_W-1){1'b1}}};
    end else if (sum_ext < -$signed((SUM_W+1)'({1'b0, 1'b1, {(SUM_W-1){1'b0}}}))) begin
      sum_sat = {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      sum_sat = SUM_W'(sum_ext);
    end
  end

  assign commit = (state_r == S_RD) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    x_origin_nxt  = x_origin_r;
    y_origin_nxt  = y_origin_r;
    x_inv_nxt     = x_inv_r;
    y_inv_nxt     = y_inv_r;
    x_bins_nxt    = x_bins_r;
    y_bins_nxt    = y_bins_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    op_nxt        = op_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    qx_nxt        = qx_r;
    qy_nxt        = qy_r;
    val_nxt       = val_r;
    rbx_nxt       = rbx_r;
    rby_nxt       = rby_r;
    hx_nxt        = hx_r;
    hy_nxt        = hy_r;
    addr_nxt      = addr_r;
    rd_ok_nxt     = rd_ok_r;
    mem_we        = 1'b0;
    mem_wa        = addr_r;
    mem_wd        = rd_word_r;

    if (cfg_valid) begin
      unique case (cfg_index)
        REG_X_ORIGIN: x_origin_nxt = cfg_data;
        REG_Y_ORIGIN: y_origin_nxt = cfg_data;
        REG_X_INV:    x_inv_nxt    = cfg_data;
        REG_Y_INV:    y_inv_nxt    = cfg_data;
        REG_X_BINS:   x_bins_nxt   = cfg_data[BINS_W-1:0];
        REG_Y_BINS:   y_bins_nxt   = cfg_data[BINS_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLR: begin
        mem_we      = 1'b1;
        mem_wa      = clr_cnt_r;
        mem_wd      = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ADDR_W'(CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_data.operation;
          dx_nxt    = (diff_x > 0) ? diff_x[31:0] : '0;
          dy_nxt    = (diff_y > 0) ? diff_y[31:0] : '0;
          val_nxt   = in_data.sample_value;
          rbx_nxt   = in_data.read_bin_x;
          rby_nxt   = in_data.read_bin_y;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        qx_nxt    = prod_x[63:32];
        qy_nxt    = prod_y[63:32];
        state_nxt = S_IDX;
      end
      S_IDX: begin
        if (op_r == OP_ADD) begin
          hx_nxt    = cl_x;
          hy_nxt    = cl_y;
          addr_nxt  = ADDR_W'(32'(cl_x) * 32'(MAX_BINS_Y) + 32'(cl_y));
          rd_ok_nxt = 1'b1;
        end else begin
          rd_ok_nxt = !rbx_r[RBIN_W-1] && !rby_r[RBIN_W-1]
                      && (BINS_W'(rbx_r[RBIN_W-2:0]) < eff_x)
                      && (BINS_W'(rby_r[RBIN_W-2:0]) < eff_y);
          addr_nxt  = ADDR_W'(32'(rbx_r[RBIN_W-2:0]) * 32'(MAX_BINS_Y)
                      + 32'(rby_r[RBIN_W-2:0]));
        end
        state_nxt = S_MEM;
      end
      S_MEM: begin
        state_nxt = S_RD;
      end
      S_RD: begin
        if (commit) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '0;
          if (op_r == OP_ADD) begin
            mem_we     = 1'b1;
            mem_wd.sum = sum_sat;
            mem_wd.cnt = (rd_word_r.cnt != CNT_MAX) ? rd_word_r.cnt + 1'b1
                                                    : rd_word_r.cnt;
            total_nxt  = (total_r != CNT_MAX) ? total_r + 1'b1 : total_r;
            out_nxt.hit_x_index   = HIT_W'(hx_r);
            out_nxt.hit_y_index   = HIT_W'(hy_r);
            out_nxt.total_entries = (total_r != CNT_MAX) ? total_r + 1'b1 : total_r;
          end else begin
            out_nxt.total_entries = total_r;
            if (rd_ok_r) begin
              out_nxt.bin_count = rd_word_r.cnt;
              out_nxt.bin_sum   = (rd_word_r.cnt != '0) ? rd_word_r.sum : '0;
            end
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      x_origin_r  <= '0;
      y_origin_r  <= '0;
      x_inv_r     <= 32'd65536;
      y_inv_r     <= 32'd65536;
      x_bins_r    <= BINS_W'(64);
      y_bins_r    <= BINS_W'(64);
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      x_origin_r  <= x_origin_nxt;
      y_origin_r  <= y_origin_nxt;
      x_inv_r     <= x_inv_nxt;
      y_inv_r     <= y_inv_nxt;
      x_bins_r    <= x_bins_nxt;
      y_bins_r    <= y_bins_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r   <= out_nxt;
    op_r    <= op_nxt;
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    qx_r    <= qx_nxt;
    qy_r    <= qy_nxt;
    val_r   <= val_nxt;
    rbx_r   <= rbx_nxt;
    rby_r   <= rby_nxt;
    hx_r    <= hx_nxt;
    hy_r    <= hy_nxt;
    addr_r  <= addr_nxt;
    rd_ok_r <= rd_ok_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_word_r <= mem[addr_r];
  end

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLR |-> !in_ready)
    else $error("input accepted during clearing pass");

  a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RD))
    else $error("result raised outside commit");

  a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> total_r >= $past(total_r))
    else $error("total entry count decreased");

  a_hit_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MEM && op_r == OP_ADD) |->
      (BINS_W'(hx_r) < eff_x) && (BINS_W'(hy_r) < eff_y))
    else $error("clamped bin index outside grid");

endmodule

@@ tb/histogram_2d_value_accumulate_checker.sv @@
// ----------------------------------------------------------------------------
// histogram_2d_value_accumulate_checker
// Watches the input, result and register-write channels of the 2-D histogram
// core. Keeps its own copy of the bin sums, bin counts, entry total and grid
// registers, predicts one result per accepted input transaction, and compares
// each accepted result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module histogram_2d_value_accumulate_checker
  import h2dva_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_item_t            out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output int                   errors,
  output int                   outstanding
);

  localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_LO = -64'sh0000_8000_0000_0000;

  logic signed [SUM_W-1:0] sum_mem [CELLS];
  logic [CNT_W-1:0]        cnt_mem [CELLS];
  logic [CNT_W-1:0]        entries;

  logic signed [31:0] org_x, org_y;
  logic [31:0]        inv_x, inv_y;
  logic [BINS_W-1:0]  nbins_x, nbins_y;

  out_item_t bin_results_q [$];
  out_item_t expd, got, pred;

  function automatic int grid_size(input logic [BINS_W-1:0] r, input int maxb);
    if (r == '0) return 1;
    if (int'(r) > maxb) return maxb;
    return int'(r);
  endfunction

  // floor((coord - origin) * inv) in Q32.32, clamped to the grid
  function automatic int axis_bin(input logic signed [31:0] c, input logic signed [31:0] o,
                                  input logic [31:0] inv, input int n);
    longint     diff;
    logic [63:0] prod;
    diff = longint'(c) - longint'(o);
    if (diff <= 0) return 0;
    prod = 64'(diff) * 64'(inv);
    if ((prod >> 32) >= 64'(n)) return n - 1;
    return int'(prod >> 32);
  endfunction

  task automatic bin_step(input in_item_t it, output out_item_t r);
    int     nx, ny, hx, hy, rx, ry, slot;
    longint acc;
    nx = grid_size(nbins_x, MAX_BINS_X);
    ny = grid_size(nbins_y, MAX_BINS_Y);
    r  = '0;
    if (op_t'(it.operation) == OP_ADD) begin
      hx   = axis_bin(it.x_coord, org_x, inv_x, nx);
      hy   = axis_bin(it.y_coord, org_y, inv_y, ny);
      slot = hx * MAX_BINS_Y + hy;
      acc  = longint'(sum_mem[slot]) + longint'(it.sample_value);
      if (acc > SUM_HI) acc = SUM_HI;
      if (acc < SUM_LO) acc = SUM_LO;
      sum_mem[slot] = acc[SUM_W-1:0];
      if (cnt_mem[slot] != CNT_MAX) cnt_mem[slot] = cnt_mem[slot] + 1'b1;
      if (entries != CNT_MAX) entries = entries + 1'b1;
      r.hit_x_index = HIT_W'(hx);
      r.hit_y_index = HIT_W'(hy);
    end else begin
      rx = int'(it.read_bin_x);
      ry = int'(it.read_bin_y);
      if (rx >= 0 && rx < nx && ry >= 0 && ry < ny) begin
        slot        = rx * MAX_BINS_Y + ry;
        r.bin_count = cnt_mem[slot];
        if (cnt_mem[slot] != '0) r.bin_sum = sum_mem[slot];
      end
    end
    r.total_entries = entries;
  endtask

  task automatic check_field(input string name, input logic [63:0] e, input logic [63:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CELLS; i++) begin
        sum_mem[i] = '0;
        cnt_mem[i] = '0;
      end
      entries = '0;
      org_x   = '0;
      org_y   = '0;
      inv_x   = 32'd65536;
      inv_y   = 32'd65536;
      nbins_x = BINS_W'(MAX_BINS_X);
      nbins_y = BINS_W'(MAX_BINS_Y);
      bin_results_q.delete();
      errors      = 0;
      outstanding = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_X_ORIGIN: org_x = cfg_data;
          REG_Y_ORIGIN: org_y = cfg_data;
          REG_X_INV:    inv_x = cfg_data;
          REG_Y_INV:    inv_y = cfg_data;
          REG_X_BINS:   nbins_x = cfg_data[BINS_W-1:0];
          REG_Y_BINS:   nbins_y = cfg_data[BINS_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = out_data;
        if (bin_results_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          errors++;
        end else begin
          expd = bin_results_q.pop_front();
          check_field("bin_sum", expd.bin_sum, got.bin_sum);
          check_field("bin_count", expd.bin_count, got.bin_count);
          check_field("hit_x_index", expd.hit_x_index, got.hit_x_index);
          check_field("hit_y_index", expd.hit_y_index, got.hit_y_index);
          check_field("total_entries", expd.total_entries, got.total_entries);
        end
      end
      if (in_valid && in_ready) begin
        bin_step(in_data, pred);
        bin_results_q = {bin_results_q, pred};
      end
      outstanding = bin_results_q.size();
    end
  end

endmodule

@@ tb/tb_histogram_2d_value_accumulate_core.sv @@
// ----------------------------------------------------------------------------
// tb_histogram_2d_value_accumulate_core
// Stimulus for the 2-D value histogram core: directed corner transactions,
// repeated extreme-value adds into single bins and randomized phases over
// several grid settings, with random idling on the input side and stalls on
// the result side. The checker instance predicts and compares; this module
// gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_histogram_2d_value_accumulate_core;
  import h2dva_pkg::*;

  localparam int                   LIMIT      = 3_000_000;
  localparam int                   PHASES     = 8;
  localparam int                   PHASE_ITEMS = 130;
  localparam int                   SAT_ADDS   = 8;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  int errors, outstanding;
  int send_idle = 0;
  int recv_stall = 0;
  int cycles = 0;
  int n_add = 0, n_read = 0, n_grids = 0;

  logic signed [31:0] cur_ox, cur_oy;
  logic [31:0]        cur_ix, cur_iy;
  int                 cur_nx, cur_ny;

  histogram_2d_value_accumulate_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  histogram_2d_value_accumulate_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic in_item_t add_item(input logic [31:0] x, input logic [31:0] y,
                                        input logic [31:0] v);
    in_item_t it;
    it.operation    = OP_ADD;
    it.x_coord      = x;
    it.y_coord      = y;
    it.sample_value = v;
    it.read_bin_x   = 8'($urandom);
    it.read_bin_y   = 8'($urandom);
    return it;
  endfunction

  function automatic in_item_t read_item(input logic [7:0] rx, input logic [7:0] ry);
    in_item_t it;
    it.operation    = OP_READ;
    it.x_coord      = $urandom;
    it.y_coord      = $urandom;
    it.sample_value = $urandom;
    it.read_bin_x   = rx;
    it.read_bin_y   = ry;
    return it;
  endfunction

  // mostly aims at a chosen bin (two past the edge included), else anywhere
  function automatic logic [31:0] pick_coord(input logic signed [31:0] org,
                                             input logic [31:0] inv, input int n);
    logic [31:0] frac;
    longint      span, c;
    frac = $urandom;
    if (inv == '0 || $urandom_range(9) < 3) return $urandom;
    span = (longint'($urandom_range(n + 1)) * 64'sh1_0000_0000 + longint'(frac))
           / longint'(inv);
    c = longint'(org) + span;
    if (c > 64'sh7FFF_FFFF) c = 64'sh7FFF_FFFF;
    return c[31:0];
  endfunction

  function automatic logic [7:0] pick_bin(input int n);
    if ($urandom_range(99) < 85) return 8'($urandom_range(n - 1));
    return 8'($urandom);
  endfunction

  function automatic logic [31:0] pick_inv();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return 32'd65536;
      3:       return $urandom;
      default: return $urandom_range(32'h0000_1000, 32'h0010_0000);
    endcase
  endfunction

  function automatic logic [6:0] pick_bins();
    if ($urandom_range(9) < 7) return 7'($urandom_range(1, MAX_BINS_X));
    return $urandom_range(1) ? 7'd0 : 7'($urandom_range(MAX_BINS_X + 1, 127));
  endfunction

  task automatic push_item(input in_item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    if (it.operation == OP_ADD) n_add++;
    else n_read++;
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
  endtask

  task automatic load_grid(input logic [31:0] ox, input logic [31:0] oy,
                           input logic [31:0] ix, input logic [31:0] iy,
                           input logic [6:0] bx, input logic [6:0] by);
    put_reg(REG_X_ORIGIN, ox);
    put_reg(REG_Y_ORIGIN, oy);
    put_reg(REG_X_INV, ix);
    put_reg(REG_Y_INV, iy);
    put_reg(REG_X_BINS, {25'($urandom), bx});
    put_reg(REG_Y_BINS, {25'($urandom), by});
    cfg_valid <= 1'b0;
    cur_ox = ox;
    cur_oy = oy;
    cur_ix = ix;
    cur_iy = iy;
    cur_nx = (bx == 0) ? 1 : ((bx > MAX_BINS_X) ? MAX_BINS_X : int'(bx));
    cur_ny = (by == 0) ? 1 : ((by > MAX_BINS_Y) ? MAX_BINS_Y : int'(by));
    n_grids++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    put_reg(REG_UNUSED, $urandom);
    load_grid(32'h0, 32'h0, 32'd65536, 32'd65536, 7'd64, 7'd64);

    // zero and negative offsets, clamp at the top edge, extreme values, reads in and out of the grid
    push_item(add_item(32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF));
    push_item(add_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    push_item(add_item(32'h0005_8000, 32'h003F_FFFF, 32'hFFFF_FFFF));
    push_item(add_item(32'h0000_0001, 32'h0040_0000, 32'h0001_0000));
    push_item(add_item(32'h003F_0000, 32'h0000_FFFF, 32'h0000_0001));
    push_item(read_item(8'd0, 8'd0));
    push_item(read_item(8'd0, 8'd63));
    push_item(read_item(8'd5, 8'd63));
    push_item(read_item(8'd63, 8'd0));
    push_item(read_item(8'd63, 8'd63));
    push_item(read_item(8'hFF, 8'd0));
    push_item(read_item(8'd0, 8'h80));
    push_item(read_item(8'd64, 8'd0));
    push_item(read_item(8'h7F, 8'h7F));
    push_item(read_item(8'd0, 8'd64));
    drain();

    // zero and all-ones inverse widths, bin counts of zero and above the max
    load_grid(32'hFFFE_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 7'd0, 7'd127);
    push_item(add_item($urandom, $urandom, $urandom));
    push_item(add_item($urandom, 32'h8000_0000, $urandom));
    push_item(read_item(8'd5, 8'd63));
    push_item(read_item(8'd0, 8'd0));
    drain();

    // grid grows back: bins outside the reduced grid kept their data
    load_grid(32'h0, 32'h0, 32'd65536, 32'd65536, 7'd64, 7'd64);
    push_item(read_item(8'd5, 8'd63));
    push_item(read_item(8'd0, 8'd0));

    // runs of extreme positive and negative values piled into single bins
    for (int i = 0; i < SAT_ADDS; i++)
      push_item(add_item(32'h000A_8000, 32'h000A_8000, 32'h7FFF_FFFF));
    push_item(read_item(8'd10, 8'd10));
    push_item(add_item(32'h000A_8000, 32'h000A_8000, 32'hFFFF_FFFF));
    push_item(read_item(8'd10, 8'd10));
    for (int i = 0; i < SAT_ADDS; i++)
      push_item(add_item(32'h0014_0000, 32'h0014_0000, 32'h8000_0000));
    push_item(read_item(8'd20, 8'd20));
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 81; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 81; end
        default: begin send_idle = 37; recv_stall = 37; end
      endcase
      case (p)
        0: load_grid(32'h0, 32'h0, 32'd65536, 32'd65536, 7'd64, 7'd64);
        1: load_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 7'd127, 7'd1);
        2: load_grid($urandom, $urandom, $urandom_range(32'h4000, 32'h10_0000),
                     $urandom_range(32'h4000, 32'h10_0000), pick_bins(), pick_bins());
        default: load_grid($urandom, $urandom, pick_inv(), pick_inv(),
                           pick_bins(), pick_bins());
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(99) < 60)
          push_item(add_item(pick_coord(cur_ox, cur_ix, cur_nx),
                             pick_coord(cur_oy, cur_iy, cur_ny), $urandom));
        else
          push_item(read_item(pick_bin(cur_nx), pick_bin(cur_ny)));
      end
      drain();
    end

    repeat (16) @(posedge clk);
    $display("Summary: %0d add and %0d read transactions over %0d grid settings,",
             n_add, n_read, n_grids);
    $display("  including runs of extreme values into one bin and out-of-grid reads");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ histogram_2d_value_accumulate_core.f @@
hw/rtl/h2dva_pkg.sv
hw/rtl/histogram_2d_value_accumulate_core.sv
tb/histogram_2d_value_accumulate_checker.sv
tb/tb_histogram_2d_value_accumulate_core.sv
